/* rtl/core/rbv_pkg.sv */
// Shared types, codes and fixed-point constants of the rigid body step core.
`default_nettype none

package rbv_pkg;

  // Fixed-point format of every state word and product.
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned PROD_BITS = 2 * WORD_BITS;

  // Register widths.
  localparam int unsigned DT_BITS   = 31;
  localparam int unsigned FRIC_BITS = 17;

  // Stream and register port widths.
  localparam int unsigned CMD_BITS   = 2;
  localparam int unsigned IN_DATA_W  = 3 * WORD_BITS;
  localparam int unsigned OUT_DATA_W = 4 * WORD_BITS;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;

  // Command codes carried in tuser of the input channel.
  localparam logic [CMD_BITS-1:0] CMD_FORCE  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_TORQUE = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_STEP   = 2'd2;

  // Operand sources of the shared multiplier and the saturating adder.
  typedef enum logic [4:0] {
    S_ZERO, S_DT, S_HALF, S_INVM, S_INVI, S_FRIC, S_FX, S_FY, S_TQ,
    S_OFFX, S_OFFY, S_VX, S_VY, S_AX, S_AY, S_PAX, S_PAY, S_ANG,
    S_RATE, S_SACC, S_PSACC, S_DTH, S_DT2H, S_TMP, S_ANGS, S_STX, S_STY,
    S_RP
  } src_e;

  // Write-back destinations.
  typedef enum logic [4:0] {
    D_DTH, D_DT2H, D_TMP, D_ANGS, D_OFFX, D_OFFY, D_VX, D_VY, D_AX, D_AY,
    D_PAX, D_PAY, D_ANG, D_RATE, D_SACC, D_PSACC, D_OUTX, D_OUTY
  } dst_e;

  // One micro-operation: optional multiply, then dst <= sat(aa + ab).
  typedef struct packed {
    logic mul;
    src_e ma;
    src_e mb;
    src_e aa;
    src_e ab;
    dst_e dst;
    logic last;
    logic report;
  } uop_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic mul_en;
    logic rnd_en;
    logic wb_en;
    logic ld_out;
    uop_t uop;
  } dp_cmd_t;

  // Configuration register contents.
  typedef struct packed {
    logic        [DT_BITS-1:0]   time_step;
    logic        [DT_BITS-1:0]   inv_mass;
    logic        [DT_BITS-1:0]   inv_inertia;
    logic        [FRIC_BITS-1:0] spin_friction;
    logic signed [WORD_BITS-1:0] start_x;
    logic signed [WORD_BITS-1:0] start_y;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/rbv_regs.sv */
// Configuration register bank behind the APB-style port.
`default_nettype none

module rbv_regs (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              psel_i,
  input  wire                              penable_i,
  input  wire                              pwrite_i,
  input  wire  [rbv_pkg::APB_ADDR_W-1:0]   paddr_i,
  input  wire  [rbv_pkg::APB_DATA_W-1:0]   pwdata_i,
  output logic [rbv_pkg::APB_DATA_W-1:0]   prdata_o,
  output logic                             pready_o,
  output rbv_pkg::cfg_t                    cfg_o
);
  import rbv_pkg::*;

  localparam logic [2:0] REG_TIME_STEP   = 3'd0;
  localparam logic [2:0] REG_INV_MASS    = 3'd1;
  localparam logic [2:0] REG_INV_INERTIA = 3'd2;
  localparam logic [2:0] REG_SPIN_FRIC   = 3'd3;
  localparam logic [2:0] REG_START_X     = 3'd4;
  localparam logic [2:0] REG_START_Y     = 3'd5;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] idx;

  assign pready_o = 1'b1;
  assign idx      = paddr_i[4:2];
  assign wr_en    = psel_i & penable_i & pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_TIME_STEP:   cfg_d.time_step     = pwdata_i[DT_BITS-1:0];
        REG_INV_MASS:    cfg_d.inv_mass      = pwdata_i[DT_BITS-1:0];
        REG_INV_INERTIA: cfg_d.inv_inertia   = pwdata_i[DT_BITS-1:0];
        REG_SPIN_FRIC:   cfg_d.spin_friction = pwdata_i[FRIC_BITS-1:0];
        REG_START_X:     cfg_d.start_x       = pwdata_i;
        REG_START_Y:     cfg_d.start_y       = pwdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step     <= DT_BITS'(1092);
      cfg_q.inv_mass      <= DT_BITS'(65536);
      cfg_q.inv_inertia   <= DT_BITS'(65536);
      cfg_q.spin_friction <= FRIC_BITS'(64881);
      cfg_q.start_x       <= '0;
      cfg_q.start_y       <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_TIME_STEP:   prdata_o = APB_DATA_W'(cfg_q.time_step);
      REG_INV_MASS:    prdata_o = APB_DATA_W'(cfg_q.inv_mass);
      REG_INV_INERTIA: prdata_o = APB_DATA_W'(cfg_q.inv_inertia);
      REG_SPIN_FRIC:   prdata_o = APB_DATA_W'(cfg_q.spin_friction);
      REG_START_X:     prdata_o = cfg_q.start_x;
      REG_START_Y:     prdata_o = cfg_q.start_y;
      default:         prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/rbv_ctrl.sv */
// Sequencer: walks the micro-op program of each command and owns the output valid.
`default_nettype none

module rbv_ctrl (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  input  wire  [rbv_pkg::CMD_BITS-1:0]   in_cmd_i,
  output logic                           in_ready_o,
  input  wire                            out_ready_i,
  output logic                           out_valid_o,
  output rbv_pkg::dp_cmd_t               cmd_o
);
  import rbv_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_RND  = 3'd2;
  localparam logic [2:0] ST_WB   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [4:0] PC_STEP   = 5'd0;
  localparam logic [4:0] PC_FORCE  = 5'd26;
  localparam logic [4:0] PC_TORQUE = 5'd28;

  function automatic uop_t mk(input logic mul, input src_e ma, input src_e mb,
                              input src_e aa, input src_e ab, input dst_e dst,
                              input logic last, input logic report);
    uop_t u;
    u.mul    = mul;
    u.ma     = ma;
    u.mb     = mb;
    u.aa     = aa;
    u.ab     = ab;
    u.dst    = dst;
    u.last   = last;
    u.report = report;
    return u;
  endfunction

  // Program store: step, force and torque sequences.
  function automatic uop_t prog(input logic [4:0] pc);
    uop_t u;
    unique case (pc)
      5'd0:  u = mk(1'b1, S_DT,    S_HALF, S_ZERO,  S_RP,   D_DTH,   1'b0, 1'b0);
      5'd1:  u = mk(1'b1, S_DT,    S_DT,   S_ZERO,  S_RP,   D_TMP,   1'b0, 1'b0);
      5'd2:  u = mk(1'b1, S_TMP,   S_HALF, S_ZERO,  S_RP,   D_DT2H,  1'b0, 1'b0);
      5'd3:  u = mk(1'b1, S_VX,    S_DT,   S_OFFX,  S_RP,   D_OFFX,  1'b0, 1'b0);
      5'd4:  u = mk(1'b1, S_AX,    S_DT2H, S_OFFX,  S_RP,   D_OFFX,  1'b0, 1'b0);
      5'd5:  u = mk(1'b1, S_VY,    S_DT,   S_OFFY,  S_RP,   D_OFFY,  1'b0, 1'b0);
      5'd6:  u = mk(1'b1, S_AY,    S_DT2H, S_OFFY,  S_RP,   D_OFFY,  1'b0, 1'b0);
      5'd7:  u = mk(1'b0, S_ZERO,  S_ZERO, S_AX,    S_PAX,  D_TMP,   1'b0, 1'b0);
      5'd8:  u = mk(1'b1, S_TMP,   S_DTH,  S_VX,    S_RP,   D_VX,    1'b0, 1'b0);
      5'd9:  u = mk(1'b0, S_ZERO,  S_ZERO, S_AY,    S_PAY,  D_TMP,   1'b0, 1'b0);
      5'd10: u = mk(1'b1, S_TMP,   S_DTH,  S_VY,    S_RP,   D_VY,    1'b0, 1'b0);
      5'd11: u = mk(1'b0, S_ZERO,  S_ZERO, S_AX,    S_ZERO, D_PAX,   1'b0, 1'b0);
      5'd12: u = mk(1'b0, S_ZERO,  S_ZERO, S_AY,    S_ZERO, D_PAY,   1'b0, 1'b0);
      5'd13: u = mk(1'b0, S_ZERO,  S_ZERO, S_ZERO,  S_ZERO, D_AX,    1'b0, 1'b0);
      5'd14: u = mk(1'b0, S_ZERO,  S_ZERO, S_ZERO,  S_ZERO, D_AY,    1'b0, 1'b0);
      5'd15: u = mk(1'b1, S_RATE,  S_DT,   S_ZERO,  S_RP,   D_ANGS,  1'b0, 1'b0);
      5'd16: u = mk(1'b1, S_SACC,  S_DT2H, S_ANGS,  S_RP,   D_ANGS,  1'b0, 1'b0);
      5'd17: u = mk(1'b0, S_ZERO,  S_ZERO, S_ANG,   S_ANGS, D_ANG,   1'b0, 1'b0);
      5'd18: u = mk(1'b0, S_ZERO,  S_ZERO, S_PSACC, S_SACC, D_TMP,   1'b0, 1'b0);
      5'd19: u = mk(1'b1, S_TMP,   S_HALF, S_ZERO,  S_RP,   D_TMP,   1'b0, 1'b0);
      5'd20: u = mk(1'b1, S_TMP,   S_DT,   S_RATE,  S_RP,   D_RATE,  1'b0, 1'b0);
      5'd21: u = mk(1'b1, S_RATE,  S_FRIC, S_ZERO,  S_RP,   D_RATE,  1'b0, 1'b0);
      5'd22: u = mk(1'b0, S_ZERO,  S_ZERO, S_SACC,  S_ZERO, D_PSACC, 1'b0, 1'b0);
      5'd23: u = mk(1'b0, S_ZERO,  S_ZERO, S_ZERO,  S_ZERO, D_SACC,  1'b0, 1'b0);
      5'd24: u = mk(1'b0, S_ZERO,  S_ZERO, S_STX,   S_OFFX, D_OUTX,  1'b0, 1'b0);
      5'd25: u = mk(1'b0, S_ZERO,  S_ZERO, S_STY,   S_OFFY, D_OUTY,  1'b1, 1'b1);
      5'd26: u = mk(1'b1, S_FX,    S_INVM, S_AX,    S_RP,   D_AX,    1'b0, 1'b0);
      5'd27: u = mk(1'b1, S_FY,    S_INVM, S_AY,    S_RP,   D_AY,    1'b1, 1'b0);
      5'd28: u = mk(1'b1, S_TQ,    S_INVI, S_SACC,  S_RP,   D_SACC,  1'b1, 1'b0);
      default: u = mk(1'b0, S_ZERO, S_ZERO, S_TMP,  S_ZERO, D_TMP,   1'b1, 1'b0);
    endcase
    return u;
  endfunction

  logic [2:0] state_q, state_d;
  logic [4:0] pc_q, pc_d, pc_inc;
  logic       outv_q, outv_d;
  uop_t       uop;

  assign uop    = prog(pc_q);
  assign pc_inc = pc_q + 5'd1;

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    cmd_o   = '0;
    cmd_o.uop = uop;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          unique case (in_cmd_i)
            CMD_FORCE: begin
              pc_d    = PC_FORCE;
              state_d = ST_MUL;
            end
            CMD_TORQUE: begin
              pc_d    = PC_TORQUE;
              state_d = ST_MUL;
            end
            CMD_STEP: begin
              pc_d    = PC_STEP;
              state_d = ST_MUL;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_RND;
      end
      ST_RND: begin
        cmd_o.rnd_en = 1'b1;
        state_d      = ST_WB;
      end
      ST_WB: begin
        cmd_o.wb_en = 1'b1;
        if (uop.last) begin
          state_d = uop.report ? ST_DONE : ST_IDLE;
        end else begin
          pc_d    = pc_inc;
          state_d = prog(pc_inc).mul ? ST_MUL : ST_WB;
        end
      end
      ST_DONE: begin
        // Hold the finished result until the output register is free.
        if (!outv_q || out_ready_i) begin
          cmd_o.ld_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    outv_d = cmd_o.ld_out | (outv_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      outv_q  <= outv_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = outv_q;

endmodule

`default_nettype wire

/* rtl/core/rbv_dpath.sv */
// Datapath: body state, shared rounding multiplier and saturating adder.
`default_nettype none

module rbv_dpath (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  rbv_pkg::dp_cmd_t                  cmd_i,
  input  rbv_pkg::cfg_t                     cfg_i,
  input  wire  [rbv_pkg::IN_DATA_W-1:0]     in_data_i,
  output logic [rbv_pkg::OUT_DATA_W-1:0]    out_data_o,
  output logic                              out_sat_o
);
  import rbv_pkg::*;

  localparam int unsigned MBITS = PROD_BITS - FRAC_BITS;
  localparam logic [PROD_BITS-1:0] RND_HALF = PROD_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [MBITS-1:0] LIM_POS = (MBITS'(1) << (WORD_BITS - 1)) - MBITS'(1);
  localparam logic [MBITS-1:0] LIM_NEG = MBITS'(1) << (WORD_BITS - 1);
  localparam logic [WORD_BITS-1:0] HALF_W = WORD_BITS'(1) << (FRAC_BITS - 1);

  // Architectural state.
  logic [WORD_BITS-1:0] offx_q, offy_q, vx_q, vy_q, ax_q, ay_q, pax_q, pay_q;
  logic [WORD_BITS-1:0] ang_q, rate_q, sacc_q, psacc_q;
  // Working registers.
  logic [WORD_BITS-1:0] dth_q, dt2h_q, tmp_q, angs_q, outx_q, outy_q;
  logic [WORD_BITS-1:0] fx_q, fy_q, tq_q, rp_q;
  logic [PROD_BITS-1:0] prod_q;
  logic                 neg_q, flag_q;
  logic [OUT_DATA_W-1:0] out_q;
  logic                 out_sat_q;

  function automatic logic [WORD_BITS-1:0] pick(input src_e s);
    logic [WORD_BITS-1:0] v;
    unique case (s)
      S_ZERO:  v = '0;
      S_DT:    v = WORD_BITS'(cfg_i.time_step);
      S_HALF:  v = HALF_W;
      S_INVM:  v = WORD_BITS'(cfg_i.inv_mass);
      S_INVI:  v = WORD_BITS'(cfg_i.inv_inertia);
      S_FRIC:  v = WORD_BITS'(cfg_i.spin_friction);
      S_FX:    v = fx_q;
      S_FY:    v = fy_q;
      S_TQ:    v = tq_q;
      S_OFFX:  v = offx_q;
      S_OFFY:  v = offy_q;
      S_VX:    v = vx_q;
      S_VY:    v = vy_q;
      S_AX:    v = ax_q;
      S_AY:    v = ay_q;
      S_PAX:   v = pax_q;
      S_PAY:   v = pay_q;
      S_ANG:   v = ang_q;
      S_RATE:  v = rate_q;
      S_SACC:  v = sacc_q;
      S_PSACC: v = psacc_q;
      S_DTH:   v = dth_q;
      S_DT2H:  v = dt2h_q;
      S_TMP:   v = tmp_q;
      S_ANGS:  v = angs_q;
      S_STX:   v = cfg_i.start_x;
      S_STY:   v = cfg_i.start_y;
      S_RP:    v = rp_q;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Multiply stage: magnitudes and product sign.
  logic [WORD_BITS-1:0] ma, mb, mag_a, mag_b;
  logic [PROD_BITS-1:0] prod_d;

  always_comb begin
    ma     = pick(cmd_i.uop.ma);
    mb     = pick(cmd_i.uop.mb);
    mag_a  = ma[WORD_BITS-1] ? (~ma + WORD_BITS'(1)) : ma;
    mag_b  = mb[WORD_BITS-1] ? (~mb + WORD_BITS'(1)) : mb;
    prod_d = PROD_BITS'(mag_a) * PROD_BITS'(mag_b);
  end

  // Round stage: half away from zero on the magnitude, then clip and sign.
  logic [PROD_BITS-1:0] lr;
  logic [MBITS-1:0]     m, lim;
  logic [WORD_BITS-1:0] mm, rnd;
  logic                 rsat;

  always_comb begin
    lr   = prod_q + RND_HALF;
    m    = lr[PROD_BITS-1:FRAC_BITS];
    lim  = neg_q ? LIM_NEG : LIM_POS;
    rsat = (m > lim);
    mm   = rsat ? lim[WORD_BITS-1:0] : m[WORD_BITS-1:0];
    rnd  = neg_q ? (~mm + WORD_BITS'(1)) : mm;
  end

  // Write-back stage: saturating add.
  logic [WORD_BITS-1:0] aa, ab, wb;
  logic [WORD_BITS:0]   sum;
  logic                 asat;

  always_comb begin
    aa   = pick(cmd_i.uop.aa);
    ab   = pick(cmd_i.uop.ab);
    sum  = {aa[WORD_BITS-1], aa} + {ab[WORD_BITS-1], ab};
    asat = (sum[WORD_BITS] != sum[WORD_BITS-1]);
    if (!asat) begin
      wb = sum[WORD_BITS-1:0];
    end else if (sum[WORD_BITS]) begin
      wb = {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      wb = {1'b0, {(WORD_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offx_q  <= '0;
      offy_q  <= '0;
      vx_q    <= '0;
      vy_q    <= '0;
      ax_q    <= '0;
      ay_q    <= '0;
      pax_q   <= '0;
      pay_q   <= '0;
      ang_q   <= '0;
      rate_q  <= '0;
      sacc_q  <= '0;
      psacc_q <= '0;
      flag_q  <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        flag_q <= 1'b0;
      end else if (cmd_i.rnd_en) begin
        flag_q <= flag_q | rsat;
      end else if (cmd_i.wb_en) begin
        flag_q <= flag_q | asat;
      end
      if (cmd_i.wb_en) begin
        unique case (cmd_i.uop.dst)
          D_OFFX:  offx_q  <= wb;
          D_OFFY:  offy_q  <= wb;
          D_VX:    vx_q    <= wb;
          D_VY:    vy_q    <= wb;
          D_AX:    ax_q    <= wb;
          D_AY:    ay_q    <= wb;
          D_PAX:   pax_q   <= wb;
          D_PAY:   pay_q   <= wb;
          D_ANG:   ang_q   <= wb;
          D_RATE:  rate_q  <= wb;
          D_SACC:  sacc_q  <= wb;
          D_PSACC: psacc_q <= wb;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      fx_q <= in_data_i[WORD_BITS-1:0];
      fy_q <= in_data_i[2*WORD_BITS-1:WORD_BITS];
      tq_q <= in_data_i[3*WORD_BITS-1:2*WORD_BITS];
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
      neg_q  <= ma[WORD_BITS-1] ^ mb[WORD_BITS-1];
    end
    if (cmd_i.rnd_en) begin
      rp_q <= rnd;
    end
    if (cmd_i.wb_en) begin
      unique case (cmd_i.uop.dst)
        D_DTH:  dth_q  <= wb;
        D_DT2H: dt2h_q <= wb;
        D_TMP:  tmp_q  <= wb;
        D_ANGS: angs_q <= wb;
        D_OUTX: outx_q <= wb;
        D_OUTY: outy_q <= wb;
        default: ;
      endcase
    end
    if (cmd_i.ld_out) begin
      out_q     <= {ang_q, angs_q, outy_q, outx_q};
      out_sat_q <= flag_q;
    end
  end

  assign out_data_o = out_q;
  assign out_sat_o  = out_sat_q;

endmodule

`default_nettype wire

/* rtl/core/rigid_body_verlet_step_2d_core.sv */
// Top level of the 2D rigid body velocity Verlet step core.
//
// Input stream: one item per command. tuser carries the command (force,
// torque or step); tdata carries force_x, force_y and torque. A force item
// adds force times inv_mass to the linear acceleration, a torque item adds
// torque times inv_inertia to the angular acceleration; neither gives a
// result. A step item integrates position, velocity and angle over the
// time step and emits one result item: positions, angle increment, total
// angle in tdata and the saturation flag in tuser. The unused command code
// is accepted and dropped.
// Sequencing: all products go through one 32x32 multiplier, each in a
// multiply, a round and a write-back step; an add is a write-back step
// alone. A step item runs 14 products, 12 adds and one output load. One
// item is worked on at a time.
// A finished result sits in an output register; a stalled receiver holds
// only a following step at its final load, force and torque items go on.
// Reset restores the register defaults and zeroes the body state.
// The user must write configuration only while the core is idle (unenforced).
`default_nettype none

module rigid_body_verlet_step_2d_core (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // Input items. tuser: cmd[1:0].
  input  wire                               s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: force_x[31:0], force_y[63:32], torque[95:64].
  input  wire  [rbv_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  input  wire  [rbv_pkg::CMD_BITS-1:0]      s_axis_tuser_i,
  // Result items. tuser: saturated[0].
  output logic                              m_axis_tvalid_o,
  input  wire                               m_axis_tready_i,
  // tdata: pos_x[31:0], pos_y[63:32], angle_step[95:64], angle_total[127:96].
  output logic [rbv_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  output logic                              m_axis_tuser_o,
  // Configuration port.
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [rbv_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire  [rbv_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rbv_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import rbv_pkg::*;

  cfg_t    cfg;
  dp_cmd_t dp_cmd;

  // Register bank: time step, reciprocals, friction and start position.
  rbv_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // Sequencer: accepts an item, steps through its program, loads the result.
  rbv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_cmd_i    (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .cmd_o       (dp_cmd)
  );

  // Datapath: body state, shared multiplier, saturating adder, result register.
  rbv_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .cfg_i      (cfg),
    .in_data_i  (s_axis_tdata_i),
    .out_data_o (m_axis_tdata_o),
    .out_sat_o  (m_axis_tuser_o)
  );

  // No arithmetic may run while the core offers to take an item.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !(dp_cmd.mul_en || dp_cmd.rnd_en || dp_cmd.wb_en))
    else $error("datapath busy while input is ready");

  // Never overwrite a result that the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.ld_out |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result register overwritten");

  // A result appears only after a load of the output register.
  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(dp_cmd.ld_out))
    else $error("result valid without a load");

  // A force item starts with a multiply in the next cycle.
  a_force_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == CMD_FORCE))
      |=> dp_cmd.mul_en)
    else $error("force item did not start a multiply");

endmodule

`default_nettype wire

/* verif/verlet_check_pkg.sv */
// Body predictor and result scoreboard for the rigid body step core testbench.
`timescale 1ns / 100ps

package verlet_check_pkg;

  typedef enum int {
    REG_TIME_STEP, REG_INV_MASS, REG_INV_INERTIA, REG_SPIN_FRICTION, REG_START_X, REG_START_Y
  } reg_e;

  localparam logic [rbv_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

  localparam longint W_MAX  = (longint'(1) << (rbv_pkg::WORD_BITS - 1)) - 1;
  localparam longint W_MIN  = -W_MAX - 1;
  localparam longint Q_HALF = longint'(1) << (rbv_pkg::FRAC_BITS - 1);

  // Laid out as {tuser, tdata} of the result channel.
  typedef struct packed {
    logic        saturated;
    logic [31:0] angle_total;
    logic [31:0] angle_step;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } pose_t;

  class verlet_scoreboard;
    longint dt, inv_m, inv_i, fric, org_x, org_y;
    longint off_x, off_y, vel_x, vel_y, acc_x, acc_y, pacc_x, pacc_y;
    longint turn, spin, spin_acc, pspin_acc;
    bit     clipped;
    pose_t  expected_poses[$];
    int     errors, steps, results, clipped_results;

    function new();
      dt    = 1092;
      inv_m = 65536;
      inv_i = 65536;
      fric  = 64881;
      org_x = 0;
      org_y = 0;
    endfunction

    function longint clip(longint v);
      if (v > W_MAX) begin
        clipped = 1'b1;
        return W_MAX;
      end
      if (v < W_MIN) begin
        clipped = 1'b1;
        return W_MIN;
      end
      return v;
    endfunction

    function longint add(longint a, longint b);
      return clip(a + b);
    endfunction

    // Round the magnitude half away from zero, then saturate.
    function longint mul(longint a, longint b);
      bit           neg;
      logic [63:0]  ma, mb;
      logic [127:0] prod, lim;
      neg  = (a < 0) != (b < 0);
      ma   = (a < 0) ? 64'(-a) : 64'(a);
      mb   = (b < 0) ? 64'(-b) : 64'(b);
      prod = {64'd0, ma} * {64'd0, mb};
      prod = (prod + 128'(Q_HALF)) >> rbv_pkg::FRAC_BITS;
      lim  = neg ? 128'(W_MAX) + 128'd1 : 128'(W_MAX);
      if (prod > lim) begin
        clipped = 1'b1;
        prod    = lim;
      end
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function longint sx(logic [31:0] v);
      return longint'($signed(v));
    endfunction

    function void set_register(reg_e idx, logic [31:0] v);
      case (idx)
        REG_TIME_STEP:     dt    = longint'(v & 32'h7FFF_FFFF);
        REG_INV_MASS:      inv_m = longint'(v & 32'h7FFF_FFFF);
        REG_INV_INERTIA:   inv_i = longint'(v & 32'h7FFF_FFFF);
        REG_SPIN_FRICTION: fric  = longint'(v & 32'h0001_FFFF);
        REG_START_X:       org_x = sx(v);
        REG_START_Y:       org_y = sx(v);
        default: ;
      endcase
    endfunction

    function logic [31:0] readback_of(reg_e idx);
      case (idx)
        REG_TIME_STEP:     return 32'(dt);
        REG_INV_MASS:      return 32'(inv_m);
        REG_INV_INERTIA:   return 32'(inv_i);
        REG_SPIN_FRICTION: return 32'(fric);
        REG_START_X:       return 32'(org_x);
        default:           return 32'(org_y);
      endcase
    endfunction

    // Advance the body by one accepted item; a step queues the pose it reports.
    function void note_item(logic [1:0] cmd, logic [31:0] fx, logic [31:0] fy,
                            logic [31:0] tq);
      longint dth, dt2h, ang, t;
      pose_t  p;
      clipped = 1'b0;
      case (cmd)
        rbv_pkg::CMD_FORCE: begin
          acc_x = add(acc_x, mul(sx(fx), inv_m));
          acc_y = add(acc_y, mul(sx(fy), inv_m));
        end
        rbv_pkg::CMD_TORQUE: spin_acc = add(spin_acc, mul(sx(tq), inv_i));
        rbv_pkg::CMD_STEP: begin
          dth    = mul(dt, Q_HALF);
          dt2h   = mul(mul(dt, dt), Q_HALF);
          off_x  = add(add(off_x, mul(vel_x, dt)), mul(acc_x, dt2h));
          off_y  = add(add(off_y, mul(vel_y, dt)), mul(acc_y, dt2h));
          vel_x  = add(vel_x, mul(add(acc_x, pacc_x), dth));
          vel_y  = add(vel_y, mul(add(acc_y, pacc_y), dth));
          pacc_x = acc_x;
          pacc_y = acc_y;
          acc_x  = 0;
          acc_y  = 0;
          ang    = add(mul(spin, dt), mul(spin_acc, dt2h));
          turn   = add(turn, ang);
          t      = mul(mul(add(pspin_acc, spin_acc), Q_HALF), dt);
          spin   = mul(add(spin, t), fric);
          pspin_acc = spin_acc;
          spin_acc  = 0;
          p.pos_x       = 32'(add(org_x, off_x));
          p.pos_y       = 32'(add(org_y, off_y));
          p.angle_step  = 32'(ang);
          p.angle_total = 32'(turn);
          p.saturated   = clipped;
          expected_poses.push_back(p);
          steps++;
        end
        default: ;
      endcase
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_result(pose_t got);
      pose_t want;
      if (expected_poses.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result %h with no step pending", $time, got);
        return;
      end
      want = expected_poses.pop_front();
      results++;
      if (got.saturated) clipped_results++;
      field_check("pos_x", want.pos_x, got.pos_x);
      field_check("pos_y", want.pos_y, got.pos_y);
      field_check("angle_step", want.angle_step, got.angle_step);
      field_check("angle_total", want.angle_total, got.angle_total);
      field_check("saturated", 32'(want.saturated), 32'(got.saturated));
    endfunction
  endclass

endpackage

/* verif/tb_top.sv */
// Self-checking testbench of the rigid body step core: random items, APB set-ups, scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import verlet_check_pkg::*;

  localparam int HOLD_CYCLES   = 600;   // long receiver hold-off to fill the core
  localparam int SETTLE_CYCLES = 80;    // beyond the longest item, a step
  localparam int PHASE_ITEMS   = 140;
  localparam int PHASES        = 12;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  // Input channel.
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [95:0] s_data  = '0;           // force_x, force_y, torque from bit 0 up
  logic [1:0]  s_user  = '0;           // cmd
  // Result channel.
  logic        m_valid;
  logic        m_rdy   = 1'b0;
  logic [127:0] m_data;                // pos_x, pos_y, angle_step, angle_total
  logic        m_user;                 // saturated
  // Register port.
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [rbv_pkg::APB_ADDR_W-1:0] paddr  = '0;
  logic [rbv_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [rbv_pkg::APB_DATA_W-1:0] prdata;
  logic        pready;

  int src_idle = 0;      // chance in a hundred that the sender holds valid low, drawn again each time
  int rx_idle  = 0;      // same for the receiver
  int hold_req = 0;      // bump to ask the receiver for one long hold-off
  int items_sent   = 0;
  int settings_set = 0;

  verlet_scoreboard body_sb = new();

  rigid_body_verlet_step_2d_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_rdy),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly small values so the body stays in range, with full-width words
  // and the corner values mixed in.
  function automatic logic [31:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    if (pick < 75) return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    if (pick < 90) return $urandom;
    case ($urandom_range(4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic [31:0] rand_recip();
    if ($urandom_range(7) == 0) return $urandom_range(0, 32'h7FFF_FFFF);
    return $urandom_range(0, 32'h0004_0000);
  endfunction

  // Offer one item from a falling edge; hold it until the core takes it and
  // return at the next falling edge with valid still high.
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] fx,
                           input logic [31:0] fy, input logic [31:0] tq);
    while ($urandom_range(99) < src_idle) begin
      s_valid = 1'b0;
      @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_user  = cmd;
    s_data  = {tq, fy, fx};
    do @(posedge clk_i); while (!s_ready);
    body_sb.note_item(cmd, fx, fy, tq);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Under step_heavy most items are steps, so results pile up behind a hold.
  task automatic send_random(input bit step_heavy);
    int unsigned      pick;
    logic [1:0]       cmd;
    pick = $urandom_range(99);
    if (step_heavy)  cmd = (pick < 70) ? rbv_pkg::CMD_STEP : rbv_pkg::CMD_FORCE;
    else if (pick < 35) cmd = rbv_pkg::CMD_STEP;
    else if (pick < 70) cmd = rbv_pkg::CMD_FORCE;
    else if (pick < 95) cmd = rbv_pkg::CMD_TORQUE;
    else                cmd = CMD_UNUSED;
    send_item(cmd, rand_word(), rand_word(), rand_word());
  endtask

  // Write one register, then read it back; the write lands at the edge that
  // closes the access cycle.
  task automatic write_register(input reg_e idx, input logic [31:0] value);
    logic [31:0] readback;
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = rbv_pkg::APB_ADDR_W'(4 * idx);
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    body_sb.set_register(idx, value);
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (readback !== body_sb.readback_of(idx)) begin
      body_sb.errors++;
      $display("%0t ns: register %s read back, expected %h, got %h", $time, idx.name(),
               body_sb.readback_of(idx), readback);
    end
  endtask

  task automatic configure(input logic [31:0] dt, input logic [31:0] im,
                           input logic [31:0] ii, input logic [31:0] fr,
                           input logic [31:0] sx, input logic [31:0] sy);
    write_register(REG_TIME_STEP, dt);
    write_register(REG_INV_MASS, im);
    write_register(REG_INV_INERTIA, ii);
    write_register(REG_SPIN_FRICTION, fr);
    write_register(REG_START_X, sx);
    write_register(REG_START_Y, sy);
    settings_set++;
  endtask

  // Drop valid, wait for every pending pose, then let a trailing force or
  // torque item finish before anything touches the registers.
  task automatic settle();
    s_valid = 1'b0;
    while (body_sb.expected_poses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Receiver: decide readiness each falling edge; a hold request keeps ready
  // low for a long stretch counted here.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_rdy = 1'b0;
      end else begin
        m_rdy = ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // Sample results at the rising edge and hand them to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_rdy) body_sb.check_result({m_user, m_data});
  end

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    src_idle = 8;
    rx_idle  = 74;

    // Directed run at the reset settings: full-scale forces and torques,
    // zero items, the unused command and back-to-back steps.
    send_item(rbv_pkg::CMD_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_item(rbv_pkg::CMD_TORQUE, 32'h0, 32'h0, 32'h7FFF_FFFF);
    send_item(rbv_pkg::CMD_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(rbv_pkg::CMD_FORCE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_item(rbv_pkg::CMD_TORQUE, 32'h0, 32'h0, 32'h8000_0000);
    send_item(rbv_pkg::CMD_STEP, 32'h0, 32'h0, 32'h0);
    send_item(rbv_pkg::CMD_FORCE, 32'h0, 32'h0, 32'h0);
    send_item(rbv_pkg::CMD_TORQUE, 32'h0, 32'h0, 32'h0);
    send_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(rbv_pkg::CMD_STEP, 32'h0, 32'h0, 32'h0);
    send_item(rbv_pkg::CMD_FORCE, 32'h0001_8000, 32'hFFFE_8000, 32'h0);
    send_item(rbv_pkg::CMD_TORQUE, 32'h0, 32'h0, 32'h0000_4000);
    send_item(rbv_pkg::CMD_FORCE, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0);
    send_item(rbv_pkg::CMD_STEP, 32'h0, 32'h0, 32'h0);
    send_item(rbv_pkg::CMD_STEP, 32'h0, 32'h0, 32'h0);
    send_item(CMD_UNUSED, 32'h0, 32'h0, 32'h0);
    send_item(rbv_pkg::CMD_TORQUE, 32'h0, 32'h0, 32'hFFFF_C000);
    send_item(rbv_pkg::CMD_STEP, 32'h0, 32'h0, 32'h0);
    settle();

    // Random phases, each under its own register setting. The corner
    // settings come last: they pin the body at its limits for good.
    for (int ph = 0; ph < PHASES; ph++) begin
      src_idle = (ph < 4) ? 8 : (ph < 8) ? 74 : 0;
      rx_idle  = (ph < 4) ? 74 : (ph < 8) ? 8 : 0;
      case (ph)
        5:  configure(32'd1, rand_recip(), rand_recip(), $urandom_range(0, 32'h1_0000),
                      rand_word(), rand_word());
        10: configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1_0000,
                      32'h7FFF_FFFF, 32'h8000_0000);
        // zero time step: positions and angles freeze, friction still bites
        11: configure(32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
        default: configure($urandom_range(1, 4096), rand_recip(), rand_recip(),
                           $urandom_range(0, 32'h1_0000), rand_word(), rand_word());
      endcase
      if (ph == 8) begin
        // hold the receiver off while steps keep coming, so the core stalls its input
        hold_req++;
        repeat (60) send_random(1'b1);
      end
      repeat (PHASE_ITEMS) send_random(1'b0);
      settle();
    end

    $display("Run covered %0d items (%0d steps, %0d results, %0d saturated) over %0d settings,",
             items_sent, body_sb.steps, body_sb.results, body_sb.clipped_results,
             settings_set + 1);
    $display("under three idling mixes and one long receiver hold-off.");
    if (body_sb.errors == 0 && body_sb.expected_poses.size() == 0) begin
      $display("[rigid_body_verlet_step_2d_core] OK");
    end else begin
      $display("[rigid_body_verlet_step_2d_core] ERROR");
    end
    $finish;
  end

  // Stop a hung run; a correct one needs well under a tenth of this.
  initial begin : watchdog
    #8_000_000;
    $display("[rigid_body_verlet_step_2d_core] ERROR");
    $finish;
  end

endmodule
